// ===== hw/rtl/edge_non_max_suppression_core_defines.svh =====
// assertion macros for the non-maximum suppression core
`ifndef EDGE_NON_MAX_SUPPRESSION_CORE_DEFINES_SVH
`define EDGE_NON_MAX_SUPPRESSION_CORE_DEFINES_SVH

// condition must hold on every clock edge out of reset
`define NMS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define NMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/nms_pkg.sv =====
// types, codes and the suppression compare shared by the nms core
`timescale 1ns / 1ps
`default_nettype none

package nms_pkg;

  // default sizing of the line store and frame height
  localparam int unsigned MaxWidthDefault    = 2048;
  localparam int unsigned MaxChannelsDefault = 4;
  localparam int unsigned MaxHeightDefault   = 4096;

  // configuration registers
  localparam int unsigned CfgWidthBits  = 12;
  localparam int unsigned CfgHeightBits = 13;
  localparam int unsigned CfgChanBits   = 3;
  localparam int unsigned CfgDataBits   = 13;
  localparam int unsigned CfgIndexBits  = 2;

  localparam logic [CfgIndexBits-1:0] CfgImageWidth  = 2'd0;
  localparam logic [CfgIndexBits-1:0] CfgImageHeight = 2'd1;
  localparam logic [CfgIndexBits-1:0] CfgChannels    = 2'd2;

  localparam logic [CfgWidthBits-1:0]  ImageWidthReset  = 12'd640;
  localparam logic [CfgHeightBits-1:0] ImageHeightReset = 13'd480;
  localparam logic [CfgChanBits-1:0]   ChannelsReset    = 3'd1;

  // input commands
  localparam logic CmdSample = 1'b0;
  localparam logic CmdDrain  = 1'b1;

  // quantized gradient directions
  localparam logic [1:0] DirVertical   = 2'd0;
  localparam logic [1:0] DirDiagDown   = 2'd1;
  localparam logic [1:0] DirHorizontal = 2'd2;
  localparam logic [1:0] DirDiagUp     = 2'd3;

  typedef struct packed {
    logic       command;
    logic [7:0] magnitude;
    logic [1:0] direction;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] magnitude_out;
    logic       end_of_frame;
    logic       last;
  } out_beat_t;

  // one column of the 3x3 neighborhood
  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
  } column_t;

  // one line store entry: previous row, the row before it, previous direction
  typedef struct packed {
    logic [1:0] dir;
    logic [7:0] row_older;
    logic [7:0] row_prev;
  } line_entry_t;

  function automatic logic [7:0] suppress(column_t l, column_t c, column_t r,
                                          logic [1:0] dir, logic top_edge);
    column_t    lc;
    column_t    cc;
    column_t    rc;
    logic [7:0] na;
    logic [7:0] nb;
    lc = l;
    cc = c;
    rc = r;
    // first output row: no row above, clamp to the middle row
    if (top_edge) begin
      lc.top = lc.mid;
      cc.top = cc.mid;
      rc.top = rc.mid;
    end
    unique case (dir)
      DirVertical: begin
        na = cc.top;
        nb = cc.bot;
      end
      DirDiagDown: begin
        na = lc.top;
        nb = rc.bot;
      end
      DirHorizontal: begin
        na = lc.mid;
        nb = rc.mid;
      end
      DirDiagUp: begin
        na = lc.bot;
        nb = rc.top;
      end
      default: begin
        na = cc.mid;
        nb = cc.mid;
      end
    endcase
    return (cc.mid >= na && cc.mid >= nb) ? cc.mid : 8'd0;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/edge_non_max_suppression_core.sv =====
// non-maximum suppression core: line store, neighborhood windows and output queue
//
// usage
// - input beats (in_valid_i / in_stall_o / in_data_i) carry gradient samples in raster
//   order, channels interleaved, or drain ticks once a frame has been fully sent
// - output beats (out_valid_o / out_stall_i / out_data_o) carry the thinned magnitudes,
//   one row behind input; a row end gives two beats (one at width 1), drain ticks one
// - a beat is taken at a rising edge with valid high and stall low
// - configuration (cfg_we_i / cfg_index_i / cfg_data_i) is written while idle; any
//   write to a known register restarts the frame
// timing
// - one input beat per cycle unless stalled; the line store is a read, modify, write
//   loop with a forwarding register for back-to-back hits on the same entry
// - a result is registered in the read stage, then in the queue that drives out_valid_o
// - the 4-entry output queue absorbs stalls; in_stall_o rises when it cannot take
//   two more results for the beat in flight plus the next one
// reset
// - registers return to 640x480, one channel; counters and queue empty
// - the line store is not cleared: the first output row never reads unwritten entries
`timescale 1ns / 1ps
`default_nettype none
`include "edge_non_max_suppression_core_defines.svh"

module edge_non_max_suppression_core #(
  parameter int unsigned MaxWidth    = nms_pkg::MaxWidthDefault,
  parameter int unsigned MaxChannels = nms_pkg::MaxChannelsDefault,
  parameter int unsigned MaxHeight   = nms_pkg::MaxHeightDefault
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  nms_pkg::in_beat_t                    in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output nms_pkg::out_beat_t                   out_data_o,
  input  wire                                  cfg_we_i,
  input  wire [nms_pkg::CfgIndexBits-1:0]      cfg_index_i,
  input  wire [nms_pkg::CfgDataBits-1:0]       cfg_data_i
);

  localparam int unsigned LineDepth = MaxWidth * MaxChannels;
  localparam int unsigned AddrW     = $clog2(LineDepth);
  localparam int unsigned XW        = $clog2(MaxWidth);
  localparam int unsigned WidthW    = $clog2(MaxWidth + 1);
  localparam int unsigned ChanW     = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned ChanNW    = $clog2(MaxChannels + 1);
  localparam int unsigned RowW      = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int unsigned HeightW   = $clog2(MaxHeight + 1);
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    KindNone,
    KindSample,
    KindDrain
  } kind_e;

  // beat in the read stage
  typedef struct packed {
    kind_e            kind;
    logic [1:0]       count;
    logic [AddrW-1:0] addr_a;
    logic [AddrW-1:0] addr_b;
    logic [ChanW-1:0] chan;
    logic             x_is0;
    logic             x_is1;
    logic             x_ge1;
    logic             top_edge;
    logic             eof;
    logic [7:0]       mag;
    logic [1:0]       dir;
  } stage_t;

  // configuration registers
  logic [nms_pkg::CfgWidthBits-1:0]  cfg_width_q;
  logic [nms_pkg::CfgHeightBits-1:0] cfg_height_q;
  logic [nms_pkg::CfgChanBits-1:0]   cfg_chan_q;
  logic                              cfg_hit;

  // clamped frame geometry
  logic [31:0]        w_raw;
  logic [31:0]        h_raw;
  logic [31:0]        c_raw;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic [ChanNW-1:0]  ch_n;

  // raster counters for incoming samples
  logic [AddrW-1:0] col_p_q;
  logic [XW-1:0]    col_x_q;
  logic [ChanW-1:0] col_ch_q;
  logic [RowW-1:0]  row_q;
  // drain position
  logic [AddrW-1:0] drn_p_q;
  logic [XW-1:0]    drn_x_q;
  logic [ChanW-1:0] drn_ch_q;
  logic             draining_q;

  // sample position after an abandoned drain is folded in
  logic [AddrW-1:0] samp_p;
  logic [XW-1:0]    samp_x;
  logic [ChanW-1:0] samp_ch;
  logic [RowW-1:0]  samp_row;
  logic             samp_x_last;
  logic             samp_ch_last;
  logic             samp_row_end;
  logic             samp_row_last;
  logic [1:0]       samp_count;
  logic             drn_x_last;
  logic             drn_ch_last;
  logic             drn_row_end;

  logic   in_fire;
  stage_t s1_d;
  stage_t s1_q;

  // line store and its forwarding register
  nms_pkg::line_entry_t line_mem [LineDepth];
  nms_pkg::line_entry_t rd_a_q;
  nms_pkg::line_entry_t rd_b_q;
  nms_pkg::line_entry_t rd_a;
  nms_pkg::line_entry_t rd_b;
  logic [AddrW-1:0]     rd_addr_a;
  logic [AddrW-1:0]     rd_addr_b;
  logic                 mem_we;
  nms_pkg::line_entry_t mem_wdata;
  logic                 fwd_vld_q;
  logic [AddrW-1:0]     fwd_addr_q;
  nms_pkg::line_entry_t fwd_data_q;

  // per-channel neighborhood windows
  nms_pkg::column_t win_l_q [MaxChannels];
  nms_pkg::column_t win_c_q [MaxChannels];
  logic [1:0]       dprev_q [MaxChannels];
  nms_pkg::column_t dleft_q [MaxChannels];
  nms_pkg::column_t win_l;
  nms_pkg::column_t win_c;
  nms_pkg::column_t fresh;
  nms_pkg::column_t drn_cur;
  nms_pkg::column_t drn_right;
  logic [7:0]       res_inner;
  logic [7:0]       res_edge;
  logic [7:0]       res_drain;
  nms_pkg::out_beat_t res0;
  nms_pkg::out_beat_t res1;

  // output queue
  nms_pkg::out_beat_t fifo_q [FifoDepth];
  logic [FifoAw-1:0]  head_q;
  logic [FifoAw-1:0]  tail_q;
  logic [FifoCw-1:0]  count_q;
  logic               pop;

  // ---------------------------------------------------------------------------
  // geometry, clamped to the line store size and the height limit
  // ---------------------------------------------------------------------------
  assign w_raw = 32'(cfg_width_q);
  assign h_raw = 32'(cfg_height_q);
  assign c_raw = 32'(cfg_chan_q);

  always_comb begin
    if (w_raw == 32'd0) begin
      w_eff = WidthW'(1);
    end else if (w_raw > MaxWidth) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = WidthW'(w_raw);
    end
    if (h_raw == 32'd0) begin
      h_eff = HeightW'(1);
    end else if (h_raw > MaxHeight) begin
      h_eff = HeightW'(MaxHeight);
    end else begin
      h_eff = HeightW'(h_raw);
    end
    if (c_raw == 32'd0) begin
      ch_n = ChanNW'(1);
    end else if (c_raw > MaxChannels) begin
      ch_n = ChanNW'(MaxChannels);
    end else begin
      ch_n = ChanNW'(c_raw);
    end
  end

  assign cfg_hit = cfg_we_i && (cfg_index_i == nms_pkg::CfgImageWidth ||
                                cfg_index_i == nms_pkg::CfgImageHeight ||
                                cfg_index_i == nms_pkg::CfgChannels);

  // ---------------------------------------------------------------------------
  // accept stage: positions, line store read
  // ---------------------------------------------------------------------------
  // a sample during a drain starts a new frame at the top
  assign samp_p   = draining_q ? '0 : col_p_q;
  assign samp_x   = draining_q ? '0 : col_x_q;
  assign samp_ch  = draining_q ? '0 : col_ch_q;
  assign samp_row = draining_q ? '0 : row_q;

  assign samp_x_last   = (WidthW'(samp_x) + WidthW'(1)) == w_eff;
  assign samp_ch_last  = (ChanNW'(samp_ch) + ChanNW'(1)) == ch_n;
  assign samp_row_end  = samp_x_last && samp_ch_last;
  assign samp_row_last = (HeightW'(samp_row) + HeightW'(1)) == h_eff;
  // inner pixel result and right border result, none on the first row
  assign samp_count = (samp_row == '0) ? 2'd0 :
                      (2'((samp_x != '0)) + 2'(samp_x_last));

  assign drn_x_last  = (WidthW'(drn_x_q) + WidthW'(1)) == w_eff;
  assign drn_ch_last = (ChanNW'(drn_ch_q) + ChanNW'(1)) == ch_n;
  assign drn_row_end = drn_x_last && drn_ch_last;

  // room for the beat in flight plus up to two results of this one
  assign in_stall_o = (count_q + FifoCw'(s1_q.count)) > FifoCw'(FifoDepth - 2);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign rd_addr_a = (in_data_i.command == nms_pkg::CmdDrain) ? drn_p_q : samp_p;
  // drain needs the right neighbor of the same channel, clamped at the border
  assign rd_addr_b = drn_x_last ? drn_p_q : (drn_p_q + AddrW'(ch_n));

  always_comb begin
    s1_d          = '0;
    s1_d.kind     = KindNone;
    s1_d.mag      = in_data_i.magnitude;
    s1_d.dir      = in_data_i.direction;
    s1_d.addr_a   = rd_addr_a;
    s1_d.addr_b   = rd_addr_b;
    if (in_fire && !cfg_hit) begin
      if (in_data_i.command == nms_pkg::CmdDrain) begin
        if (draining_q) begin
          s1_d.kind     = KindDrain;
          s1_d.count    = 2'd1;
          s1_d.chan     = drn_ch_q;
          s1_d.x_is0    = (drn_x_q == '0);
          s1_d.top_edge = (h_eff == HeightW'(1));
          s1_d.eof      = drn_row_end;
        end
      end else begin
        s1_d.kind     = KindSample;
        s1_d.count    = samp_count;
        s1_d.chan     = samp_ch;
        s1_d.x_is0    = (samp_x == '0);
        s1_d.x_is1    = (samp_x == XW'(1));
        s1_d.x_ge1    = (samp_x != '0);
        s1_d.top_edge = (samp_row == RowW'(1));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= nms_pkg::ImageWidthReset;
      cfg_height_q <= nms_pkg::ImageHeightReset;
      cfg_chan_q   <= nms_pkg::ChannelsReset;
      col_p_q      <= '0;
      col_x_q      <= '0;
      col_ch_q     <= '0;
      row_q        <= '0;
      drn_p_q      <= '0;
      drn_x_q      <= '0;
      drn_ch_q     <= '0;
      draining_q   <= 1'b0;
      s1_q         <= '0;
    end else begin
      s1_q <= s1_d;
      if (cfg_hit) begin
        unique case (cfg_index_i)
          nms_pkg::CfgImageWidth:  cfg_width_q  <= cfg_data_i[nms_pkg::CfgWidthBits-1:0];
          nms_pkg::CfgImageHeight: cfg_height_q <= cfg_data_i[nms_pkg::CfgHeightBits-1:0];
          nms_pkg::CfgChannels:    cfg_chan_q   <= cfg_data_i[nms_pkg::CfgChanBits-1:0];
          default: ;
        endcase
        // any write to a known register restarts the frame
        col_p_q    <= '0;
        col_x_q    <= '0;
        col_ch_q   <= '0;
        row_q      <= '0;
        drn_p_q    <= '0;
        drn_x_q    <= '0;
        drn_ch_q   <= '0;
        draining_q <= 1'b0;
      end else if (in_fire) begin
        if (in_data_i.command == nms_pkg::CmdDrain) begin
          // drain tick outside a drain does nothing
          if (draining_q) begin
            if (drn_row_end) begin
              drn_p_q    <= '0;
              drn_x_q    <= '0;
              drn_ch_q   <= '0;
              draining_q <= 1'b0;
            end else if (drn_ch_last) begin
              drn_p_q  <= drn_p_q + AddrW'(1);
              drn_x_q  <= drn_x_q + XW'(1);
              drn_ch_q <= '0;
            end else begin
              drn_p_q  <= drn_p_q + AddrW'(1);
              drn_ch_q <= drn_ch_q + ChanW'(1);
            end
          end
        end else begin
          drn_p_q  <= '0;
          drn_x_q  <= '0;
          drn_ch_q <= '0;
          if (samp_row_end) begin
            col_p_q  <= '0;
            col_x_q  <= '0;
            col_ch_q <= '0;
            if (samp_row_last) begin
              row_q      <= '0;
              draining_q <= 1'b1;
            end else begin
              row_q      <= samp_row + RowW'(1);
              draining_q <= 1'b0;
            end
          end else begin
            col_p_q    <= samp_p + AddrW'(1);
            row_q      <= samp_row;
            draining_q <= 1'b0;
            if (samp_ch_last) begin
              col_x_q  <= samp_x + XW'(1);
              col_ch_q <= '0;
            end else begin
              col_x_q  <= samp_x;
              col_ch_q <= samp_ch + ChanW'(1);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // line store: two read ports, one write port, read data registered
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[s1_q.addr_a] <= mem_wdata;
    end
    rd_a_q <= line_mem[rd_addr_a];
    rd_b_q <= line_mem[rd_addr_b];
  end

  // write landing on the edge the read was taken: read returned the old word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= mem_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= s1_q.addr_a;
    fwd_data_q <= mem_wdata;
  end

  assign rd_a = (fwd_vld_q && fwd_addr_q == s1_q.addr_a) ? fwd_data_q : rd_a_q;
  assign rd_b = (fwd_vld_q && fwd_addr_q == s1_q.addr_b) ? fwd_data_q : rd_b_q;

  // ---------------------------------------------------------------------------
  // read stage: window shift, compares, write back
  // ---------------------------------------------------------------------------
  assign mem_we              = (s1_q.kind == KindSample);
  assign mem_wdata.dir       = s1_q.dir;
  assign mem_wdata.row_older = rd_a.row_prev;
  assign mem_wdata.row_prev  = s1_q.mag;

  assign win_l = win_l_q[s1_q.chan];
  assign win_c = win_c_q[s1_q.chan];

  // new column: two rows back, previous row, current sample
  assign fresh.top = rd_a.row_older;
  assign fresh.mid = rd_a.row_prev;
  assign fresh.bot = s1_q.mag;

  // last row in the drain: no row below, clamp to the middle row
  assign drn_cur.top   = rd_a.row_older;
  assign drn_cur.mid   = rd_a.row_prev;
  assign drn_cur.bot   = rd_a.row_prev;
  assign drn_right.top = rd_b.row_older;
  assign drn_right.mid = rd_b.row_prev;
  assign drn_right.bot = rd_b.row_prev;

  // pixel left of the newest column, left border clamps onto itself
  assign res_inner = nms_pkg::suppress(s1_q.x_is1 ? win_c : win_l, win_c, fresh,
                                       dprev_q[s1_q.chan], s1_q.top_edge);
  // right border pixel: right neighbor clamps onto itself, left too in one-pixel rows
  assign res_edge  = nms_pkg::suppress(s1_q.x_is0 ? fresh : win_c, fresh, fresh,
                                       rd_a.dir, s1_q.top_edge);
  assign res_drain = nms_pkg::suppress(s1_q.x_is0 ? drn_cur : dleft_q[s1_q.chan],
                                       drn_cur, drn_right, rd_a.dir, s1_q.top_edge);

  always_comb begin
    res0 = '0;
    res1 = '0;
    if (s1_q.kind == KindDrain) begin
      res0.magnitude_out = res_drain;
      res0.end_of_frame  = s1_q.eof;
      res0.last          = 1'b1;
    end else if (s1_q.count == 2'd2) begin
      res0.magnitude_out = res_inner;
      res1.magnitude_out = res_edge;
      res1.last          = 1'b1;
    end else begin
      res0.magnitude_out = s1_q.x_ge1 ? res_inner : res_edge;
      res0.last          = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.kind == KindSample) begin
      win_l_q[s1_q.chan] <= win_c;
      win_c_q[s1_q.chan] <= fresh;
      dprev_q[s1_q.chan] <= rd_a.dir;
    end
    if (s1_q.kind == KindDrain) begin
      dleft_q[s1_q.chan] <= drn_cur;
    end
  end

  // ---------------------------------------------------------------------------
  // output queue
  // ---------------------------------------------------------------------------
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = fifo_q[head_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (s1_q.count != 2'd0) begin
      fifo_q[tail_q] <= res0;
    end
    if (s1_q.count == 2'd2) begin
      fifo_q[tail_q + FifoAw'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_q + FifoAw'(pop);
      tail_q  <= tail_q + FifoAw'(s1_q.count);
      count_q <= count_q + FifoCw'(s1_q.count) - FifoCw'(pop);
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `NMS_ASSERT(a_queue_credit, (count_q + FifoCw'(s1_q.count)) <= FifoCw'(FifoDepth), "queue overrun")
  `NMS_ASSERT_IMP(a_drain_idle, draining_q, col_p_q == '0 && row_q == '0, "counters busy in drain")
  `NMS_ASSERT_NEXT(a_drain_done, in_fire && in_data_i.command == nms_pkg::CmdDrain && draining_q && drn_row_end, !draining_q, "drain did not end")
  `NMS_ASSERT_IMP(a_eof_last, out_valid_o && out_data_o.end_of_frame, out_data_o.last, "frame end not last")

endmodule

`default_nettype wire

// ===== tb/tb_edge_non_max_suppression_core.sv =====
// self-checking testbench for the non-maximum suppression core
`timescale 1ns / 1ps

module tb_edge_non_max_suppression_core;
  import nms_pkg::*;

  // line store size of the default build
  localparam int unsigned LineLen = MaxWidthDefault * MaxChannelsDefault;
  // register index that maps to no register: a write must be ignored
  localparam logic [CfgIndexBits-1:0] CfgUnused = 2'd3;
  // cycles to let a beat with no result leave the pipe before a register write
  localparam int unsigned SettleCycles = 10;
  // long receiver hold-off, long enough to fill the output queue
  localparam int unsigned HoldOffCycles = 250;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  in_beat_t                in_data_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  out_beat_t               out_data_o;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0]  cfg_data_i = '0;

  edge_non_max_suppression_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: register copies, line stores, windows and frame counters
  // ---------------------------------------------------------------------------
  bit [CfgWidthBits-1:0]  cfg_width  = ImageWidthReset;
  bit [CfgHeightBits-1:0] cfg_height = ImageHeightReset;
  bit [CfgChanBits-1:0]   cfg_chans  = ChannelsReset;

  // [0] holds row r-1, [1] holds row r-2, per sample position
  bit [7:0]    line_mag [2][LineLen];
  bit [1:0]    line_dir [LineLen];
  // per channel 3x3 magnitude window: [column][row], column 0 oldest,
  // row 0 top (r-2), row 1 middle (r-1), row 2 bottom (current row)
  bit [7:0]    win_mag [MaxChannelsDefault][3][3];
  bit [1:0]    win_dir [MaxChannelsDefault][2];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned drain_pos;
  bit          draining;

  out_beat_t   thinned_expected [$];
  int unsigned mismatch_count;
  int unsigned work_beats;      // accepted beats that were not ignored
  bit          idle_en = 1'b1;  // random gaps and stalls on both sides
  int unsigned hold_cycles;     // receiver hold-off still to run

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned eff_width();
    return clamp_u(cfg_width, 1, MaxWidthDefault);
  endfunction

  function automatic int unsigned eff_height();
    return clamp_u(cfg_height, 1, MaxHeightDefault);
  endfunction

  function automatic int unsigned eff_chans();
    return clamp_u(cfg_chans, 1, MaxChannelsDefault);
  endfunction

  function automatic int unsigned row_length();
    return eff_width() * eff_chans();
  endfunction

  // keep the centre sample if it is at least both neighbors along the direction
  // t, m, b: top, middle, bottom rows; element 0 left, 1 centre, 2 right
  function automatic bit [7:0] thin_pixel(bit [2:0][7:0] t, bit [2:0][7:0] m,
                                          bit [2:0][7:0] b, bit [1:0] dir);
    bit [7:0] na;
    bit [7:0] nb;
    case (dir)
      DirVertical: begin
        na = t[1];
        nb = b[1];
      end
      DirDiagDown: begin
        na = t[0];
        nb = b[2];
      end
      DirHorizontal: begin
        na = m[0];
        nb = m[2];
      end
      DirDiagUp: begin
        na = b[0];
        nb = t[2];
      end
    endcase
    return (m[1] >= na && m[1] >= nb) ? m[1] : 8'd0;
  endfunction

  // thin the centre of a window built from three window columns
  function automatic bit [7:0] window_thin(int unsigned ch, int unsigned c0, int unsigned c1,
                                           int unsigned c2, bit top_edge, bit [1:0] dir);
    int unsigned   cols [3];
    bit [2:0][7:0] t;
    bit [2:0][7:0] m;
    bit [2:0][7:0] b;
    cols[0] = c0;
    cols[1] = c1;
    cols[2] = c2;
    for (int i = 0; i < 3; i++) begin
      m[i] = win_mag[ch][cols[i]][1];
      // first output row has nothing above: clamp to the middle row
      t[i] = top_edge ? m[i] : win_mag[ch][cols[i]][0];
      b[i] = win_mag[ch][cols[i]][2];
    end
    return thin_pixel(t, m, b, dir);
  endfunction

  function automatic void restart_frame();
    col_pos   = 0;
    row_pos   = 0;
    drain_pos = 0;
    draining  = 1'b0;
  endfunction

  // work out the thinned results of one accepted beat and queue them
  function automatic void predict_thinning(in_beat_t beat);
    int unsigned   w;
    int unsigned   h;
    int unsigned   nch;
    int unsigned   rowlen;
    int unsigned   p;
    int unsigned   x;
    int unsigned   ch;
    int unsigned   q;
    int unsigned   n;
    int unsigned   cols [3];
    bit [2:0][7:0] t;
    bit [2:0][7:0] m;
    bit [7:0]      r1;
    bit [7:0]      r2;
    bit [1:0]      d1;
    bit            top_edge;
    out_beat_t     res [2];
    w      = eff_width();
    h      = eff_height();
    nch    = eff_chans();
    rowlen = w * nch;
    n      = 0;
    if (beat.command == CmdDrain) begin
      // drain tick outside a drain is ignored
      if (draining) begin
        work_beats++;
        p       = drain_pos % rowlen;
        x       = p / nch;
        ch      = p % nch;
        cols[0] = (x == 0) ? x : x - 1;
        cols[1] = x;
        cols[2] = (x + 1 >= w) ? x : x + 1;
        // last row: nothing below, so bottom is the middle row
        for (int i = 0; i < 3; i++) begin
          q    = cols[i] * nch + ch;
          m[i] = line_mag[0][q];
          t[i] = (h == 1) ? m[i] : line_mag[1][q];
        end
        res[0].magnitude_out = thin_pixel(t, m, m, line_dir[p]);
        res[0].end_of_frame  = (p + 1 == rowlen);
        res[0].last          = 1'b1;
        n                    = 1;
        drain_pos            = p + 1;
        if (drain_pos >= rowlen) begin
          draining  = 1'b0;
          drain_pos = 0;
        end
      end
    end else begin
      work_beats++;
      // a sample during a drain abandons it and opens a new frame
      if (draining) restart_frame();
      if (col_pos >= rowlen) col_pos = 0;
      p        = col_pos;
      x        = p / nch;
      ch       = p % nch;
      r1       = line_mag[0][p];
      r2       = line_mag[1][p];
      d1       = line_dir[p];
      top_edge = (row_pos == 1);
      line_mag[1][p] = r1;
      line_mag[0][p] = beat.magnitude;
      line_dir[p]    = beat.direction;
      for (int i = 0; i < 3; i++) begin
        win_mag[ch][0][i] = win_mag[ch][1][i];
        win_mag[ch][1][i] = win_mag[ch][2][i];
      end
      win_mag[ch][2][0] = r2;
      win_mag[ch][2][1] = r1;
      win_mag[ch][2][2] = beat.magnitude;
      win_dir[ch][0]    = win_dir[ch][1];
      win_dir[ch][1]    = d1;
      if (row_pos >= 1) begin
        // pixel x-1 of the row above; left neighbor clamped at x-1 == 0
        if (x >= 1) begin
          res[n].magnitude_out = window_thin(ch, (x == 1) ? 1 : 0, 1, 2, top_edge,
                                             win_dir[ch][0]);
          n++;
        end
        // row end: the last pixel of the row above too, right neighbor clamped
        if (x + 1 == w) begin
          res[n].magnitude_out = window_thin(ch, (x == 0) ? 2 : 1, 2, 2, top_edge,
                                             win_dir[ch][1]);
          n++;
        end
      end
      for (int unsigned k = 0; k < n; k++) begin
        res[k].end_of_frame = 1'b0;
        res[k].last         = (k == n - 1);
      end
      col_pos = p + 1;
      if (col_pos >= rowlen) begin
        col_pos = 0;
        if (row_pos + 1 >= h) begin
          row_pos   = 0;
          draining  = 1'b1;
          drain_pos = 0;
        end else begin
          row_pos++;
        end
      end
    end
    for (int unsigned k = 0; k < n; k++) thinned_expected.push_back(res[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // compare each accepted output beat with the oldest expectation
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (thinned_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected output beat %0d/%0b/%0b",
                                  out_data_o.magnitude_out, out_data_o.end_of_frame,
                                  out_data_o.last));
      end else begin
        want = thinned_expected.pop_front();
        if (out_data_o.magnitude_out !== want.magnitude_out)
          report_mismatch($sformatf("magnitude_out got %0d want %0d",
                                    out_data_o.magnitude_out, want.magnitude_out));
        if (out_data_o.end_of_frame !== want.end_of_frame)
          report_mismatch($sformatf("end_of_frame got %0b want %0b",
                                    out_data_o.end_of_frame, want.end_of_frame));
        if (out_data_o.last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_data_o.last, want.last));
      end
    end
  end

  // receiver: long hold-off when asked, else random stalls with a probability of 19 in 100
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(99) < 19);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one beat, with a random gap first, and wait until it is taken
  task automatic send_beat(in_beat_t beat);
    int unsigned gap;
    gap = (idle_en && $urandom_range(99) < 19) ? $urandom_range(4, 1) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    predict_thinning(beat);
  endtask

  task automatic send_sample(logic [7:0] mag, logic [1:0] dir);
    in_beat_t beat;
    beat.command   = CmdSample;
    beat.magnitude = mag;
    beat.direction = dir;
    send_beat(beat);
  endtask

  // drain ticks carry random payload bits, which the block ignores
  task automatic send_drains(int unsigned count);
    in_beat_t beat;
    repeat (count) begin
      beat.command   = CmdDrain;
      beat.magnitude = $urandom_range(255);
      beat.direction = $urandom_range(3);
      send_beat(beat);
    end
  endtask

  // magnitudes: full range, clusters for ties, and the extremes
  function automatic logic [7:0] random_mag();
    case ($urandom_range(3))
      0: return $urandom_range(255);
      1: return $urandom_range(3);
      2: return $urandom_range(255, 252);
      default: return $urandom_range(1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  task automatic send_samples(int unsigned count);
    repeat (count) send_sample(random_mag(), $urandom_range(3));
  endtask

  // one whole frame of samples followed by its drain
  task automatic send_frame();
    send_samples(eff_height() * row_length());
    send_drains(row_length());
  endtask

  // wait for every expected result; valid stays as it is
  task automatic wait_results();
    while (thinned_expected.size() != 0) @(posedge clk_i);
  endtask

  // quiet the sender, collect every result, let any beat without result retire
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(logic [CfgIndexBits-1:0] idx, logic [CfgDataBits-1:0] data);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CfgImageWidth: begin
        cfg_width = data[CfgWidthBits-1:0];
        restart_frame();
      end
      CfgImageHeight: begin
        cfg_height = data[CfgHeightBits-1:0];
        restart_frame();
      end
      CfgChannels: begin
        cfg_chans = data[CfgChanBits-1:0];
        restart_frame();
      end
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [CfgDataBits-1:0] w, logic [CfgDataBits-1:0] h,
                              logic [CfgDataBits-1:0] ch);
    write_reg(CfgImageWidth, w);
    write_reg(CfgImageHeight, h);
    write_reg(CfgChannels, ch);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked 3x3 frame: all directions, extreme magnitudes, ties, stray drains
  task automatic test_directed_frame();
    // drain tick straight after reset: nothing to drain
    send_drains(1);
    set_geometry(3, 3, 1);
    send_sample(8'd255, DirVertical);
    send_sample(8'd0,   DirDiagDown);
    send_sample(8'd128, DirHorizontal);
    send_sample(8'd7,   DirDiagUp);
    send_sample(8'd200, DirVertical);
    send_sample(8'd200, DirHorizontal);
    send_sample(8'd0,   DirDiagDown);
    send_sample(8'd255, DirDiagUp);
    send_sample(8'd1,   DirVertical);
    send_drains(3);
    // drain already finished: ignored
    send_drains(1);
  endtask

  // one-pixel rows of two channels, a drain cut short by a new frame
  task automatic test_abandoned_drain();
    set_geometry(1, 2, 2);
    send_sample(8'd5,  DirVertical);
    send_sample(8'd9,  DirHorizontal);
    send_sample(8'd5,  DirVertical);
    send_sample(8'd10, DirDiagUp);
    send_drains(1);
    send_sample(8'd3,  DirDiagDown);
    send_sample(8'd4,  DirVertical);
    send_frame();
  endtask

  // out-of-range and largest register values, unmapped index
  task automatic test_register_extremes();
    // zero everywhere clamps to a single one-channel pixel per frame
    set_geometry(0, 0, 0);
    repeat (4) send_frame();
    // unmapped register index mid-frame: no restart
    set_geometry(3, 2, 7);
    send_samples(row_length() + 5);
    write_reg(CfgUnused, 13'h1FFF);
    send_samples(row_length() - 5);
    send_drains(row_length());
    // widest row, data wider than the register
    set_geometry(13'h1FFF, 1, 1);
    send_frame();
    // largest in-range values; a partial frame, then restarted by a write
    set_geometry(2048, 4096, 4);
    send_samples(20);
    set_geometry(2, 13'h1FFF, 13'h1FFF);
    send_samples(5 * row_length());
  endtask

  // receiver holds off while the sender keeps offering, then the sender pauses
  task automatic test_backpressure();
    set_geometry(4, 3, 2);
    hold_cycles = HoldOffCycles;
    repeat (2) send_frame();
    // sender pause until the output side is empty
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_results();
    send_frame();
  endtask

  // full rate on both sides
  task automatic test_full_rate();
    set_geometry(5, 3, 3);
    idle_en = 1'b0;
    repeat (3) send_frame();
    settle();
    idle_en = 1'b1;
  endtask

  // random geometries with mostly whole frames, some cut short or noisy
  task automatic test_random_frames();
    int unsigned target;
    int unsigned kind;
    logic [CfgDataBits-1:0] w;
    logic [CfgDataBits-1:0] h;
    logic [CfgDataBits-1:0] ch;
    in_beat_t noise;
    target = work_beats + 800;
    while (work_beats < target) begin
      w  = ($urandom_range(99) < 8) ? 0 : $urandom_range(6, 1);
      h  = ($urandom_range(99) < 8) ? 0 : $urandom_range(4, 1);
      ch = ($urandom_range(99) < 10) ? $urandom_range(7, 5) : $urandom_range(4, 0);
      set_geometry(w, h, ch);
      repeat ($urandom_range(3, 1)) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          send_frame();
          // stray drains after the drain is over
          if ($urandom_range(9) == 0) send_drains($urandom_range(2, 1));
        end else if (kind < 80) begin
          // cut the drain short; the next frame starts at once
          send_samples(eff_height() * row_length());
          send_drains($urandom_range(row_length() - 1));
          send_frame();
        end else if (kind < 90) begin
          send_samples($urandom_range(eff_height() * row_length()));
        end else begin
          repeat ($urandom_range(10, 1)) begin
            noise = in_beat_t'($urandom);
            send_beat(noise);
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_frame();
    test_abandoned_drain();
    test_register_extremes();
    test_backpressure();
    test_full_rate();
    test_random_frames();
    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard limit on the run
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/nms_pkg.sv
hw/rtl/edge_non_max_suppression_core.sv
tb/tb_edge_non_max_suppression_core.sv
